// ----- sv/sgfa_pkg.sv -----
// shared types and constants of the softened gravity force accumulator
`timescale 1ns / 1ps

package sgfa_pkg;

    localparam int DEF_INDEX_BITS = 16;
    localparam int DEF_COORD_BITS = 32;
    localparam int QUOT_BITS      = 63;
    localparam int MASS_BITS      = 32;
    localparam int EPS_BITS       = 32;
    localparam int FORCE_BITS     = 64;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_START,
        OP_MUL_STEP,
        OP_MUL_STORE,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ACC,
        OP_STICKY,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        M_DX,
        M_DY,
        M_DZ,
        M_EPS,
        M_R2,
        M_R3,
        M_MM,
        M_NUM
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel sel;
    } t_cmd;

    typedef struct packed {
        logic equal;
        logic last;
        logic s_zero;
        logic mul_last;
        logic sqrt_last;
        logic div_last;
        logic ax_last;
        logic out_free;
    } t_sts;

endpackage

// ----- sv/sgfa_ctrl.sv -----
// sequencing state machine of the force accumulator
`timescale 1ns / 1ps

module sgfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sgfa_pkg::t_sts    i_sts,
    output sgfa_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CHECK   = 13'b0000000000010,
        S_MSTART  = 13'b0000000000100,
        S_MRUN    = 13'b0000000001000,
        S_MSTORE  = 13'b0000000010000,
        S_ZCHK    = 13'b0000000100000,
        S_SQRUN   = 13'b0000001000000,
        S_DSTART  = 13'b0000010000000,
        S_DRUN    = 13'b0000100000000,
        S_ACC     = 13'b0001000000000,
        S_FIN     = 13'b0010000000000,
        S_EMIT    = 13'b0100000000000,
        S_SPARE   = 13'b1000000000000
    } t_state;

    t_state          r_state, n_state;
    sgfa_pkg::t_msel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= sgfa_pkg::M_DX;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd.op   = sgfa_pkg::OP_NONE;
        o_cmd.sel  = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = sgfa_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.equal) begin
                    n_state = S_FIN;
                end else begin
                    n_sel   = sgfa_pkg::M_DX;
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.op = sgfa_pkg::OP_MUL_START;
                n_state  = S_MRUN;
            end
            S_MRUN: begin
                o_cmd.op = sgfa_pkg::OP_MUL_STEP;
                if (i_sts.mul_last) n_state = S_MSTORE;
            end
            S_MSTORE: begin
                o_cmd.op = sgfa_pkg::OP_MUL_STORE;
                n_state  = S_MSTART;
                case (r_sel)
                    sgfa_pkg::M_DX:  n_sel = sgfa_pkg::M_DY;
                    sgfa_pkg::M_DY:  n_sel = sgfa_pkg::M_DZ;
                    sgfa_pkg::M_DZ:  n_sel = sgfa_pkg::M_EPS;
                    sgfa_pkg::M_EPS: n_state = S_ZCHK;
                    sgfa_pkg::M_R2:  n_sel = sgfa_pkg::M_R3;
                    sgfa_pkg::M_R3:  n_sel = sgfa_pkg::M_MM;
                    sgfa_pkg::M_MM:  n_sel = sgfa_pkg::M_NUM;
                    default:         n_state = S_DSTART;
                endcase
            end
            S_ZCHK: begin
                if (i_sts.s_zero) begin
                    o_cmd.op = sgfa_pkg::OP_STICKY;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = sgfa_pkg::OP_SQRT_START;
                    n_state  = S_SQRUN;
                end
            end
            S_SQRUN: begin
                o_cmd.op = sgfa_pkg::OP_SQRT_STEP;
                if (i_sts.sqrt_last) begin
                    n_sel   = sgfa_pkg::M_R2;
                    n_state = S_MSTART;
                end
            end
            S_DSTART: begin
                o_cmd.op = sgfa_pkg::OP_DIV_START;
                n_state  = S_DRUN;
            end
            S_DRUN: begin
                o_cmd.op = sgfa_pkg::OP_DIV_STEP;
                if (i_sts.div_last) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = sgfa_pkg::OP_ACC;
                if (i_sts.ax_last) begin
                    n_state = S_FIN;
                end else begin
                    n_sel   = sgfa_pkg::M_NUM;
                    n_state = S_MSTART;
                end
            end
            S_FIN: begin
                n_state = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = sgfa_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sgfa_dp.sv -----
// datapath: shift-add multiplier, square root, divider and accumulators
`timescale 1ns / 1ps

module sgfa_dp #(
    parameter int INDEX_BITS = sgfa_pkg::DEF_INDEX_BITS,
    parameter int COORD_BITS = sgfa_pkg::DEF_COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sgfa_pkg::t_cmd                       i_cmd,
    output sgfa_pkg::t_sts                       o_sts,
    input  logic                                 i_cfg_we,
    input  logic [sgfa_pkg::EPS_BITS-1:0]        i_cfg_data,
    input  logic [INDEX_BITS-1:0]                i_target_index,
    input  logic signed [COORD_BITS-1:0]         i_target_x,
    input  logic signed [COORD_BITS-1:0]         i_target_y,
    input  logic signed [COORD_BITS-1:0]         i_target_z,
    input  logic [sgfa_pkg::MASS_BITS-1:0]       i_target_mass,
    input  logic [INDEX_BITS-1:0]                i_source_index,
    input  logic signed [COORD_BITS-1:0]         i_source_x,
    input  logic signed [COORD_BITS-1:0]         i_source_y,
    input  logic signed [COORD_BITS-1:0]         i_source_z,
    input  logic [sgfa_pkg::MASS_BITS-1:0]       i_source_mass,
    input  logic                                 i_first_of_run,
    input  logic                                 i_last_of_run,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [INDEX_BITS-1:0]                o_result_index,
    output logic signed [sgfa_pkg::FORCE_BITS-1:0] o_force_x,
    output logic signed [sgfa_pkg::FORCE_BITS-1:0] o_force_y,
    output logic signed [sgfa_pkg::FORCE_BITS-1:0] o_force_z,
    output logic                                 o_overflow_flag
);

    localparam int FB   = sgfa_pkg::FORCE_BITS;
    localparam int QB   = sgfa_pkg::QUOT_BITS;
    localparam int MAGW = COORD_BITS + 1;
    localparam int SQW  = (2 * MAGW > 64) ? 2 * MAGW : 64;
    localparam int SW   = SQW + 2;
    localparam int RW   = (SW + 1) / 2;
    localparam int DW   = 3 * RW;
    localparam int NW   = 64 + MAGW + 32;
    localparam int BW0  = (MAGW > RW) ? MAGW : RW;
    localparam int BW   = (BW0 > 32) ? BW0 : 32;
    localparam int AW0  = (2 * RW > 64) ? 2 * RW : 64;
    localparam int AW   = (AW0 > MAGW) ? AW0 : MAGW;
    localparam int PW   = AW + BW;
    localparam int HW   = NW - QB;
    localparam int CMPW = (HW > DW) ? HW : DW;
    localparam int LIM0 = (BW > RW) ? BW : RW;
    localparam int LIM  = (LIM0 > QB) ? LIM0 : QB;
    localparam int CW   = $clog2(LIM + 1);

    // control state
    logic [FB-1:0]          r_sum [3];
    logic                   r_sticky;
    logic [sgfa_pkg::EPS_BITS-1:0] r_eps;
    logic                   r_ovalid;
    logic [1:0]             r_ax;
    logic [CW-1:0]          r_cnt;

    // payload
    logic [INDEX_BITS-1:0]  r_tidx;
    logic                   r_equal;
    logic                   r_last;
    logic [MAGW-1:0]        r_mag [3];
    logic                   r_neg [3];
    logic [sgfa_pkg::MASS_BITS-1:0] r_m1, r_m2;
    logic [SW-1:0]          r_s;
    logic [2*RW-1:0]        r_sqs;
    logic [RW:0]            r_sqrem;
    logic [RW-1:0]          r_r;
    logic [DW-1:0]          r_d;
    logic [63:0]            r_mm;
    logic [NW-1:0]          r_num;
    logic [DW-1:0]          r_rem;
    logic [QB-1:0]          r_divlo;
    logic [QB-1:0]          r_q;
    logic                   r_sat;
    logic [PW-1:0]          r_ma, r_mp;
    logic [BW-1:0]          r_mb;
    logic [INDEX_BITS-1:0]  r_oidx;
    logic [FB-1:0]          r_ofx, r_ofy, r_ofz;
    logic                   r_oflag;

    logic [COORD_BITS:0]    dif [3];
    logic [PW-1:0]          op_a;
    logic [BW-1:0]          op_b;
    logic [RW+2:0]          sq_rem2, sq_trial, sq_diff;
    logic                   sq_ge;
    logic [HW-1:0]          div_hi;
    logic [CMPW-1:0]        div_hi_c, div_d_c;
    logic [DW:0]            div_t, div_dext, div_diff;
    logic                   div_ge;
    logic [FB-1:0]          acc_mag, acc_term, acc_a, acc_sum;
    logic                   acc_ovf;
    logic                   out_free;

    assign dif[0] = {i_target_x[COORD_BITS-1], i_target_x}
                  - {i_source_x[COORD_BITS-1], i_source_x};
    assign dif[1] = {i_target_y[COORD_BITS-1], i_target_y}
                  - {i_source_y[COORD_BITS-1], i_source_y};
    assign dif[2] = {i_target_z[COORD_BITS-1], i_target_z}
                  - {i_source_z[COORD_BITS-1], i_source_z};

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.sel)
            sgfa_pkg::M_DX: begin
                op_a = PW'(r_mag[0]);
                op_b = BW'(r_mag[0]);
            end
            sgfa_pkg::M_DY: begin
                op_a = PW'(r_mag[1]);
                op_b = BW'(r_mag[1]);
            end
            sgfa_pkg::M_DZ: begin
                op_a = PW'(r_mag[2]);
                op_b = BW'(r_mag[2]);
            end
            sgfa_pkg::M_EPS: begin
                op_a = PW'(r_eps);
                op_b = BW'(r_eps);
            end
            sgfa_pkg::M_R2: begin
                op_a = PW'(r_r);
                op_b = BW'(r_r);
            end
            sgfa_pkg::M_R3: begin
                op_a = PW'(r_d[2*RW-1:0]);
                op_b = BW'(r_r);
            end
            sgfa_pkg::M_MM: begin
                op_a = PW'(r_m1);
                op_b = BW'(r_m2);
            end
            default: begin
                op_a = PW'(r_mm);
                op_b = BW'(r_mag[r_ax]);
            end
        endcase
    end

    // square root digit step
    assign sq_rem2  = {r_sqrem, r_sqs[2*RW-1 -: 2]};
    assign sq_trial = {1'b0, r_r, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign sq_diff  = sq_rem2 - sq_trial;

    // divider
    assign div_hi   = r_num[NW-1:QB];
    assign div_hi_c = CMPW'(div_hi);
    assign div_d_c  = CMPW'(r_d);
    assign div_t    = {r_rem, r_divlo[QB-1]};
    assign div_dext = {1'b0, r_d};
    assign div_ge   = (div_t >= div_dext);
    assign div_diff = div_t - div_dext;

    // saturating accumulate
    assign acc_mag  = r_sat ? {1'b0, {(FB-1){1'b1}}} : {1'b0, r_q};
    assign acc_term = r_neg[r_ax] ? (~acc_mag + FB'(1)) : acc_mag;
    assign acc_a    = r_sum[r_ax];
    assign acc_sum  = acc_a + acc_term;
    assign acc_ovf  = (acc_a[FB-1] == acc_term[FB-1]) && (acc_sum[FB-1] != acc_a[FB-1]);

    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_sticky <= 1'b0;
            r_eps    <= '0;
            r_ovalid <= 1'b0;
            r_ax     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) r_eps <= i_cfg_data;
            if (i_cmd.op == sgfa_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                sgfa_pkg::OP_LOAD: begin
                    r_ax <= '0;
                    if (i_first_of_run) begin
                        r_sum[0] <= '0;
                        r_sum[1] <= '0;
                        r_sum[2] <= '0;
                        r_sticky <= 1'b0;
                    end
                end
                sgfa_pkg::OP_MUL_START,
                sgfa_pkg::OP_SQRT_START,
                sgfa_pkg::OP_DIV_START: begin
                    r_cnt <= '0;
                end
                sgfa_pkg::OP_MUL_STEP,
                sgfa_pkg::OP_SQRT_STEP,
                sgfa_pkg::OP_DIV_STEP: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                sgfa_pkg::OP_ACC: begin
                    r_sum[r_ax] <= acc_ovf ? (acc_a[FB-1] ? {1'b1, {(FB-1){1'b0}}}
                                                          : {1'b0, {(FB-1){1'b1}}})
                                           : acc_sum;
                    r_sticky    <= r_sticky | acc_ovf | r_sat;
                    r_ax        <= r_ax + 2'd1;
                end
                sgfa_pkg::OP_STICKY: begin
                    r_sticky <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sgfa_pkg::OP_LOAD: begin
                r_tidx  <= i_target_index;
                r_equal <= (i_target_index == i_source_index);
                r_last  <= i_last_of_run;
                r_m1    <= i_target_mass;
                r_m2    <= i_source_mass;
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= dif[k][COORD_BITS];
                    r_mag[k] <= dif[k][COORD_BITS] ? (~dif[k] + MAGW'(1)) : dif[k];
                end
            end
            sgfa_pkg::OP_MUL_START: begin
                r_ma <= op_a;
                r_mb <= op_b;
                r_mp <= '0;
            end
            sgfa_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) r_mp <= r_mp + r_ma;
                r_ma <= {r_ma[PW-2:0], 1'b0};
                r_mb <= {1'b0, r_mb[BW-1:1]};
            end
            sgfa_pkg::OP_MUL_STORE: begin
                case (i_cmd.sel)
                    sgfa_pkg::M_DX:  r_s   <= r_mp[SW-1:0];
                    sgfa_pkg::M_DY,
                    sgfa_pkg::M_DZ,
                    sgfa_pkg::M_EPS: r_s   <= r_s + r_mp[SW-1:0];
                    sgfa_pkg::M_R2:  r_d   <= {{RW{1'b0}}, r_mp[2*RW-1:0]};
                    sgfa_pkg::M_R3:  r_d   <= r_mp[DW-1:0];
                    sgfa_pkg::M_MM:  r_mm  <= r_mp[63:0];
                    default:         r_num <= {r_mp[NW-33:0], 32'd0};
                endcase
            end
            sgfa_pkg::OP_SQRT_START: begin
                r_sqs   <= (2*RW)'(r_s);
                r_sqrem <= '0;
                r_r     <= '0;
            end
            sgfa_pkg::OP_SQRT_STEP: begin
                r_sqs   <= {r_sqs[2*RW-3:0], 2'b00};
                r_sqrem <= sq_ge ? sq_diff[RW:0] : sq_rem2[RW:0];
                r_r     <= {r_r[RW-2:0], sq_ge};
            end
            sgfa_pkg::OP_DIV_START: begin
                r_sat   <= (div_hi_c >= div_d_c);
                r_rem   <= div_hi_c[DW-1:0];
                r_divlo <= r_num[QB-1:0];
                r_q     <= '0;
            end
            sgfa_pkg::OP_DIV_STEP: begin
                r_rem   <= div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
                r_q     <= {r_q[QB-2:0], div_ge};
                r_divlo <= {r_divlo[QB-2:0], 1'b0};
            end
            sgfa_pkg::OP_EMIT: begin
                r_oidx  <= r_tidx;
                r_ofx   <= r_sum[0];
                r_ofy   <= r_sum[1];
                r_ofz   <= r_sum[2];
                r_oflag <= r_sticky;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.equal     = r_equal;
    assign o_sts.last      = r_last;
    assign o_sts.s_zero    = (r_s == '0);
    assign o_sts.mul_last  = (r_cnt == CW'(BW - 1));
    assign o_sts.sqrt_last = (r_cnt == CW'(RW - 1));
    assign o_sts.div_last  = (r_cnt == CW'(QB - 1));
    assign o_sts.ax_last   = (r_ax == 2'd2);
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_ovalid;
    assign o_result_index  = r_oidx;
    assign o_force_x       = r_ofx;
    assign o_force_y       = r_ofy;
    assign o_force_z       = r_ofz;
    assign o_overflow_flag = r_oflag;

endmodule

// ----- sv/softened_gravity_force_accumulator.sv -----
// top level of the softened direct-gravity force accumulator
//
//  channel   direction  handshake                payload
//  s         in         i_s_tvalid / o_s_tready  i_s_tdata, i_s_tuser, i_s_tlast
//  m         out        o_m_tvalid / i_m_tready  o_m_tdata, o_m_tuser
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data (softening length)
//
// one pair at a time; a pair with distinct indices is worked by the bit-serial multiplier
// (BW steps), square root (RW steps) and divider (63 steps); a result is emitted only
// after the last pair of a run; a zero-distance pair skips the root and divider and sets
// the overflow flag; a pair with equal indices adds no force
// reset is synchronous; sums, flag and softening length clear to zero
// a pending result is held in the output register; the next emit waits for it
`timescale 1ns / 1ps

module softened_gravity_force_accumulator #(
    parameter int INDEX_BITS = sgfa_pkg::DEF_INDEX_BITS,
    parameter int COORD_BITS = sgfa_pkg::DEF_COORD_BITS,
    parameter int IN_W  = ((2 * INDEX_BITS + 6 * COORD_BITS + 64 + 7) / 8) * 8,
    parameter int OUT_W = ((INDEX_BITS + 192 + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // target_index, target_x, target_y, target_z, target_mass,
    // source_index, source_x, source_y, source_z, source_mass
    input  logic [IN_W-1:0]               i_s_tdata,
    // first_of_run
    input  logic                          i_s_tuser,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // result_index, force_x, force_y, force_z
    output logic [OUT_W-1:0]              o_m_tdata,
    // overflow_flag
    output logic                          o_m_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sgfa_pkg::EPS_BITS-1:0] i_cfg_data
);

    localparam int IB   = INDEX_BITS;
    localparam int CB   = COORD_BITS;
    localparam int MB   = sgfa_pkg::MASS_BITS;
    localparam int O_TX = IB;
    localparam int O_TY = O_TX + CB;
    localparam int O_TZ = O_TY + CB;
    localparam int O_TM = O_TZ + CB;
    localparam int O_SI = O_TM + MB;
    localparam int O_SX = O_SI + IB;
    localparam int O_SY = O_SX + CB;
    localparam int O_SZ = O_SY + CB;
    localparam int O_SM = O_SZ + CB;

    sgfa_pkg::t_cmd cmd;
    sgfa_pkg::t_sts sts;
    logic [IB-1:0]  res_idx;
    logic [sgfa_pkg::FORCE_BITS-1:0] fx, fy, fz;

    assign o_cfg_ready = i_rst_n;

    sgfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgfa_dp #(
        .INDEX_BITS (INDEX_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_target_index  (i_s_tdata[IB-1:0]),
        .i_target_x      (i_s_tdata[O_TX +: CB]),
        .i_target_y      (i_s_tdata[O_TY +: CB]),
        .i_target_z      (i_s_tdata[O_TZ +: CB]),
        .i_target_mass   (i_s_tdata[O_TM +: MB]),
        .i_source_index  (i_s_tdata[O_SI +: IB]),
        .i_source_x      (i_s_tdata[O_SX +: CB]),
        .i_source_y      (i_s_tdata[O_SY +: CB]),
        .i_source_z      (i_s_tdata[O_SZ +: CB]),
        .i_source_mass   (i_s_tdata[O_SM +: MB]),
        .i_first_of_run  (i_s_tuser),
        .i_last_of_run   (i_s_tlast),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_result_index  (res_idx),
        .o_force_x       (fx),
        .o_force_y       (fy),
        .o_force_z       (fz),
        .o_overflow_flag (o_m_tuser)
    );

    assign o_m_tdata = OUT_W'({fz, fy, fx, res_idx});

endmodule

// ----- tb/tb_softened_gravity_force_accumulator.sv -----
// self-checking testbench for the softened gravity force accumulator: directed table then random runs
`timescale 1ns / 1ps

module tb_softened_gravity_force_accumulator;

    localparam int  IN_W     = 288;
    localparam int  OUT_W    = 208;
    localparam int  DRAIN    = 800;
    localparam int  LIMIT    = 4000000;
    localparam int  N_RANDOM = 900;
    localparam logic [63:0] POS_MAX = 64'h7fffffffffffffff;
    localparam logic [63:0] NEG_MAX = 64'h8000000000000000;

    typedef struct {
        logic [15:0] tidx;
        logic [31:0] tx, ty, tz, tm;
        logic [15:0] sidx;
        logic [31:0] sx, sy, sz, sm;
        bit          first, last;
    } t_pair;

    typedef struct packed {
        logic [15:0] idx;
        logic [63:0] fx, fy, fz;
        logic        ovf;
    } t_force;

    typedef struct {
        t_pair  p;
        bit     typed;
        t_force want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             i_s_tuser = 1'b0;
    logic             i_s_tlast = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic             o_m_tuser;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [sgfa_pkg::EPS_BITS-1:0] i_cfg_data = '0;

    softened_gravity_force_accumulator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] eps_q;
    logic [63:0] acc_x, acc_y, acc_z;
    logic        acc_ovf;
    t_force      force_q[$];
    int          n_mismatch = 0;
    int          cycles = 0;
    bit          fast_in = 0, fast_out = 0;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            acc_ovf = 1'b1;
            return a[63] ? NEG_MAX : POS_MAX;
        end
        return r;
    endfunction

    function automatic void add_force(t_pair p);
        logic signed [33:0] d;
        logic [255:0] mag[3];
        bit           neg[3];
        logic [255:0] s, cand, r, r3, mm, q;
        logic [31:0]  tp[3], sp[3];
        logic [63:0]  term;
        tp = '{p.tx, p.ty, p.tz};
        sp = '{p.sx, p.sy, p.sz};
        s = '0;
        for (int k = 0; k < 3; k++) begin
            d = $signed({{2{tp[k][31]}}, tp[k]}) - $signed({{2{sp[k][31]}}, sp[k]});
            neg[k] = d[33];
            mag[k] = neg[k] ? 256'(-d) : 256'(d);
            mag[k] = mag[k] & 256'h3_ffff_ffff;
            s = s + mag[k] * mag[k];
        end
        s = s + 256'(eps_q) * 256'(eps_q);
        if (s == 0) begin
            acc_ovf = 1'b1;
            return;
        end
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = r | (256'd1 << i);
            if (cand * cand <= s) r = cand;
        end
        r3 = r * r * r;
        mm = 256'(p.tm) * 256'(p.sm);
        for (int k = 0; k < 3; k++) begin
            term = '0;
            if (mag[k] != 0 && mm != 0) begin
                q = ((mm * mag[k]) << 32) / r3;
                if (q > 256'(POS_MAX)) begin
                    q = 256'(POS_MAX);
                    acc_ovf = 1'b1;
                end
                term = neg[k] ? -q[63:0] : q[63:0];
            end
            case (k)
                0: acc_x = sat_sum(acc_x, term);
                1: acc_y = sat_sum(acc_y, term);
                default: acc_z = sat_sum(acc_z, term);
            endcase
        end
    endfunction

    function automatic bit step_force(t_pair p, output t_force f);
        if (p.first) begin
            acc_x = '0; acc_y = '0; acc_z = '0; acc_ovf = 1'b0;
        end
        if (p.tidx != p.sidx) add_force(p);
        f = '{p.tidx, acc_x, acc_y, acc_z, acc_ovf};
        return p.last;
    endfunction

    task automatic send_pair(t_pair p, bit typed, t_force want);
        int     gap;
        t_force f;
        gap = fast_in ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.sm, p.sz, p.sy, p.sx, p.sidx, p.tm, p.tz, p.ty, p.tx, p.tidx};
        i_s_tuser  <= p.first;
        i_s_tlast  <= p.last;
        do @(posedge i_clk); while (!o_s_tready);
        if (step_force(p, f)) force_q.push_back(typed ? want : f);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        wait (force_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eps_q = v;
    endtask

    function automatic t_pair mk(logic [15:0] ti, logic [31:0] tx, ty, tz, tm,
                                 logic [15:0] si, logic [31:0] sx, sy, sz, sm,
                                 bit first, bit last);
        return '{ti, tx, ty, tz, tm, si, sx, sy, sz, sm, first, last};
    endfunction

    function automatic t_pair rnd_pair(bit first, bit last);
        t_pair p;
        int    mode;
        mode = $urandom_range(0, 9);
        p.tidx = 16'($urandom);
        p.sidx = ($urandom_range(0, 7) == 0) ? p.tidx : 16'($urandom);
        {p.tx, p.ty, p.tz} = {$urandom, $urandom, $urandom};
        if (mode < 6) begin
            p.sx = p.tx + $urandom_range(0, 32'h40000) - 32'h20000;
            p.sy = p.ty + $urandom_range(0, 32'h40000) - 32'h20000;
            p.sz = p.tz + $urandom_range(0, 32'h40000) - 32'h20000;
            p.tm = $urandom_range(0, 32'h200000);
            p.sm = $urandom_range(0, 32'h200000);
        end else if (mode == 6) begin
            {p.sx, p.sy, p.sz} = {p.tx, p.ty, p.tz};
            p.tm = $urandom;
            p.sm = $urandom;
        end else begin
            {p.sx, p.sy, p.sz} = {$urandom, $urandom, $urandom};
            p.tm = $urandom;
            p.sm = $urandom;
        end
        p.first = first;
        p.last  = last;
        return p;
    endfunction

    // result side stalls
    initial begin
        int n;
        forever begin
            n = fast_out ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_force got, want;
        if (o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[15:0], o_m_tdata[79:16], o_m_tdata[143:80],
                    o_m_tdata[207:144], o_m_tuser};
            if (force_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected transfer idx=%h", got.idx);
            end else begin
                want = force_q.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch exp idx=%h f=%h %h %h ovf=%b",
                                  " got idx=%h f=%h %h %h ovf=%b"},
                                 want.idx, want.fx, want.fy, want.fz, want.ovf,
                                 got.idx, got.fx, got.fy, got.fz, got.ovf);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** softened_gravity_force_accumulator: FAILED **");
            $finish;
        end
    end

    initial begin
        t_row        rows[$];
        t_force      none;
        logic [31:0] one, eps_set[5];
        int          sent, len;
        bit          noise;
        none = '{16'h0, 64'h0, 64'h0, 64'h0, 1'b0};
        one  = 32'h0001_0000;
        eps_q = '0; acc_x = '0; acc_y = '0; acc_z = '0; acc_ovf = 1'b0;

        rows.push_back('{mk(16'd5, 1, 2, 3, one, 16'd5, 9, 8, 7, one, 1, 1), 1,
                         '{16'd5, 64'h0, 64'h0, 64'h0, 1'b0}});
        rows.push_back('{mk(16'd7, 4, 4, 4, one, 16'd8, 4, 4, 4, one, 1, 1), 1,
                         '{16'd7, 64'h0, 64'h0, 64'h0, 1'b1}});
        rows.push_back('{mk(16'd9, one, 0, 0, 0, 16'd1, 0, 0, 0, 0, 1, 1), 1,
                         '{16'd9, 64'h0, 64'h0, 64'h0, 1'b0}});
        rows.push_back('{mk(16'h0, 32'h7fffffff, 0, 0, '1, 16'hffff, 32'h80000000, 0, 0, '1,
                            1, 1), 0, none});
        rows.push_back('{mk(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000, '1, 16'h0,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '1, 1, 1), 0, none});
        rows.push_back('{mk(16'd3, one, 0, 0, one, 16'd4, 0, 0, 0, one, 1, 1), 0, none});
        rows.push_back('{mk(16'd3, 0, one, 0, one, 16'd4, 0, 0, one, one, 1, 0), 0, none});
        rows.push_back('{mk(16'd3, 0, 0, 0, one, 16'd6, -one, one, 0, one, 0, 0), 0, none});
        rows.push_back('{mk(16'd3, 0, 0, 0, one, 16'd3, one, one, one, one, 0, 0), 0, none});
        rows.push_back('{mk(16'd3, 5, 0, -5, one, 16'd2, 0, 5, 0, one, 0, 1), 0, none});
        rows.push_back('{mk(16'd2, 1, 1, 1, '1, 16'd1, 0, 0, 0, '1, 1, 0), 0, none});
        rows.push_back('{mk(16'd2, 1, 1, 1, '1, 16'd1, 0, 0, 0, '1, 0, 0), 0, none});
        rows.push_back('{mk(16'd2, -1, -1, -1, '1, 16'd1, 0, 0, 0, '1, 0, 1), 0, none});
        rows.push_back('{mk(16'd2, 0, 0, 0, one, 16'd2, 0, 0, 0, one, 0, 1), 0, none});
        rows.push_back('{mk(16'd11, 0, 0, 0, '1, 16'd12, 0, 0, 0, '1, 0, 1), 0, none});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].want);
        wait_idle();

        eps_set = '{32'hffffffff, 32'h1, 32'h0001_0000, $urandom, 32'h0};
        sent = 0;
        foreach (eps_set[ph]) begin
            write_eps(eps_set[ph]);
            fast_in  = $urandom_range(0, 3) == 0;
            fast_out = $urandom_range(0, 3) == 0;
            while (sent < (ph + 1) * N_RANDOM / 5) begin
                noise = $urandom_range(0, 9) == 0;
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if (noise)
                        send_pair(rnd_pair(1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))), 0, none);
                    else
                        send_pair(rnd_pair(k == 0, k == len - 1), 0, none);
                    sent++;
                end
                if ($urandom_range(0, 15) == 0) begin
                    fast_in  = !fast_in;
                    fast_out = 1'($urandom_range(0, 1));
                end
            end
            wait_idle();
        end

        if (n_mismatch == 0 && force_q.size() == 0)
            $display("** softened_gravity_force_accumulator: PASSED **");
        else
            $display("** softened_gravity_force_accumulator: FAILED **");
        $finish;
    end

endmodule

// ----- softened_gravity_force_accumulator.f -----
sv/sgfa_pkg.sv
sv/sgfa_ctrl.sv
sv/sgfa_dp.sv
sv/softened_gravity_force_accumulator.sv
tb/tb_softened_gravity_force_accumulator.sv
